// ===== hw/rtl/cla_pkg.sv =====
// ----------------------------------------------------------------------------
// cla_pkg
// Shared types and constants for the console line assembler.
// ----------------------------------------------------------------------------
package cla_pkg;

    localparam int LINE_DEPTH_DEFAULT = 32;

    localparam int BYTE_W  = 8;
    localparam int CHAR_W  = 7;
    localparam int LIMIT_W = 6;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

    localparam logic [CHAR_W-1:0] CH_NUL = 7'h00;
    localparam logic [CHAR_W-1:0] CH_BS  = 7'h08;
    localparam logic [CHAR_W-1:0] CH_LF  = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_CR  = 7'h0D;
    localparam logic [CHAR_W-1:0] CH_DEL = 7'h7F;

    localparam logic DEST_ECHO = 1'b0;
    localparam logic DEST_LINE = 1'b1;

    // what an accepted byte does
    typedef enum logic [2:0] {
        KIND_ERASE,
        KIND_CR,
        KIND_LF_SWALLOW,
        KIND_LF,
        KIND_STORE,
        KIND_CUT
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ECHO,
        ST_ECHO_LF,
        ST_EMPTY,
        ST_MEM,
        ST_TERM
    } state_t;

    typedef enum logic [2:0] {
        SEL_CHAR,
        SEL_LF_ECHO,
        SEL_LF_LINE,
        SEL_MEM,
        SEL_TERM
    } out_sel_t;

    typedef struct packed {
        logic     accept;
        logic     load;
        out_sel_t sel;
        logic     last;
        logic     rd_adv;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  out_free;
        logic  line_empty;
        logic  rd_last;
    } status_t;

endpackage

// ===== hw/rtl/console_line_assembler.sv =====
// ----------------------------------------------------------------------------
// console_line_assembler
// Serial console line discipline: echo, erase, line end and line delivery.
// ----------------------------------------------------------------------------
// After a byte is accepted the sequencer enters its echo step, which loads
//   the output register when it is free. Each byte gives N results (0 to
//   LINE_DEPTH+3), moved one a cycle while the output is free; a swallowed
//   LF gives none. No new byte is taken until the last result is loaded.
// Reset: synchronous, active low; clears fill count, previous character,
//   sequencer and output valid, and sets the limit to 32. Line store is
//   not cleared.
module console_line_assembler #(
    parameter int LINE_DEPTH = cla_pkg::LINE_DEPTH_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [cla_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] received_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [cla_pkg::BYTE_W-1:0]  m_tdata,   // [6:0] data_byte, [7] zero
    output logic                        m_tuser,   // [0] destination
    output logic                        m_tlast,
    input  logic                        cfg_wr_en,
    input  logic [cla_pkg::LIMIT_W-1:0] cfg_wr_data // line_limit
);

    cla_pkg::cmd_t    cmd;
    cla_pkg::status_t status;

    cla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cla_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

`ifndef SYNTH
    // one request at a time; a swallowed LF leaves the sequencer idle
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && status.kind != cla_pkg::KIND_LF_SWALLOW
        |=> !s_tready)
        else $error("request accepted back to back");

    // no new request while a result sequence is still under way
    a_busy_mid_sequence: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request accepted in mid sequence");

    // a line always ends with its zero terminator
    a_line_terminated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && m_tuser |-> m_tdata == '0)
        else $error("completed line not terminated by zero");
`endif

endmodule

// ===== hw/rtl/cla_ctrl.sv =====
// ----------------------------------------------------------------------------
// cla_ctrl
// Sequencer: takes one byte, then steps through its echo and line results.
// ----------------------------------------------------------------------------
module cla_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  cla_pkg::status_t  status,
    output cla_pkg::cmd_t     cmd
);

    cla_pkg::state_t state_reg, state_next;
    cla_pkg::kind_t  kind_reg, kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cla_pkg::ST_IDLE;
            kind_reg  <= cla_pkg::KIND_ERASE;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    cla_pkg::state_t line_entry;

    always_comb begin
        if (!status.line_empty) begin
            line_entry = cla_pkg::ST_MEM;
        end else if (kind_reg == cla_pkg::KIND_CUT) begin
            line_entry = cla_pkg::ST_TERM;
        end else begin
            line_entry = cla_pkg::ST_EMPTY;
        end
    end

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        s_tready   = 1'b0;
        cmd        = '{accept: 1'b0, load: 1'b0, sel: cla_pkg::SEL_CHAR,
                       last: 1'b0, rd_adv: 1'b0};
        case (state_reg)
            cla_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    kind_next  = status.kind;
                    if (status.kind != cla_pkg::KIND_LF_SWALLOW) begin
                        state_next = cla_pkg::ST_ECHO;
                    end
                end
            end
            cla_pkg::ST_ECHO: begin
                // LF byte echoes itself here, so LF and CR share this step
                if (status.out_free) begin
                    cmd.load = 1'b1;
                    cmd.sel  = cla_pkg::SEL_CHAR;
                    case (kind_reg)
                        cla_pkg::KIND_ERASE,
                        cla_pkg::KIND_STORE: begin
                            cmd.last   = 1'b1;
                            state_next = cla_pkg::ST_IDLE;
                        end
                        cla_pkg::KIND_CR: begin
                            state_next = cla_pkg::ST_ECHO_LF;
                        end
                        cla_pkg::KIND_LF,
                        cla_pkg::KIND_CUT: begin
                            state_next = line_entry;
                        end
                        default: begin
                            cmd.last   = 1'b1;
                            state_next = cla_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            cla_pkg::ST_ECHO_LF: begin
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    cmd.sel    = cla_pkg::SEL_LF_ECHO;
                    state_next = line_entry;
                end
            end
            cla_pkg::ST_EMPTY: begin
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    cmd.sel    = cla_pkg::SEL_LF_LINE;
                    state_next = cla_pkg::ST_TERM;
                end
            end
            cla_pkg::ST_MEM: begin
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    cmd.sel    = cla_pkg::SEL_MEM;
                    cmd.rd_adv = !status.rd_last;
                    if (status.rd_last) begin
                        state_next = cla_pkg::ST_TERM;
                    end
                end
            end
            cla_pkg::ST_TERM: begin
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    cmd.sel    = cla_pkg::SEL_TERM;
                    cmd.last   = 1'b1;
                    state_next = cla_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cla_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/cla_datapath.sv =====
// ----------------------------------------------------------------------------
// cla_datapath
// Line store, fill count, limit register, byte decode and output register.
// ----------------------------------------------------------------------------
module cla_datapath #(
    parameter int LINE_DEPTH = cla_pkg::LINE_DEPTH_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cla_pkg::cmd_t               cmd,
    output cla_pkg::status_t            status,
    input  logic [cla_pkg::BYTE_W-1:0]  s_tdata,
    input  logic                        cfg_wr_en,
    input  logic [cla_pkg::LIMIT_W-1:0] cfg_wr_data,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [cla_pkg::BYTE_W-1:0]  m_tdata,
    output logic                        m_tuser,
    output logic                        m_tlast
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int FW = $clog2(LINE_DEPTH + 1);
    localparam logic [cla_pkg::LIMIT_W-1:0] DEPTH_LIM = cla_pkg::LIMIT_W'(LINE_DEPTH);

    logic [cla_pkg::LIMIT_W-1:0] limit_reg;
    logic [FW-1:0]               fill_reg, fill_next;
    logic [FW-1:0]               len_reg, len_next;
    logic [cla_pkg::CHAR_W-1:0]  prev_reg, prev_next;
    logic [cla_pkg::CHAR_W-1:0]  char_reg;
    logic [AW-1:0]               rd_idx_reg, rd_idx_next;
    logic [cla_pkg::CHAR_W-1:0]  rdata_reg;
    logic [cla_pkg::CHAR_W-1:0]  mem [LINE_DEPTH];

    logic                        out_valid_reg;
    logic                        out_dest_reg;
    logic [cla_pkg::CHAR_W-1:0]  out_data_reg;
    logic                        out_last_reg;

    logic [cla_pkg::CHAR_W-1:0]  c;
    logic [cla_pkg::LIMIT_W-1:0] lim;
    cla_pkg::kind_t              kind;

    assign c = s_tdata[cla_pkg::CHAR_W-1:0];

    always_comb begin
        if (limit_reg == '0) begin
            lim = cla_pkg::LIMIT_W'(1);
        end else if (limit_reg > DEPTH_LIM) begin
            lim = DEPTH_LIM;
        end else begin
            lim = limit_reg;
        end
    end

    always_comb begin
        if (c == cla_pkg::CH_BS || c == cla_pkg::CH_DEL) begin
            kind = cla_pkg::KIND_ERASE;
        end else if (c == cla_pkg::CH_CR) begin
            kind = cla_pkg::KIND_CR;
        end else if (c == cla_pkg::CH_LF) begin
            kind = (prev_reg == cla_pkg::CH_CR) ? cla_pkg::KIND_LF_SWALLOW
                                                : cla_pkg::KIND_LF;
        end else if (cla_pkg::LIMIT_W'(fill_reg) < lim) begin
            kind = cla_pkg::KIND_STORE;
        end else begin
            kind = cla_pkg::KIND_CUT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= cla_pkg::LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        fill_next = fill_reg;
        len_next  = len_reg;
        prev_next = prev_reg;
        if (cmd.accept) begin
            case (kind)
                cla_pkg::KIND_ERASE: begin
                    if (fill_reg != '0) begin
                        fill_next = fill_reg - FW'(1);
                    end
                end
                cla_pkg::KIND_CR: begin
                    len_next  = fill_reg;
                    fill_next = '0;
                    prev_next = cla_pkg::CH_CR;
                end
                cla_pkg::KIND_LF_SWALLOW: begin
                    prev_next = cla_pkg::CH_NUL;
                end
                cla_pkg::KIND_LF: begin
                    len_next  = fill_reg;
                    fill_next = '0;
                end
                cla_pkg::KIND_STORE: begin
                    fill_next = fill_reg + FW'(1);
                    prev_next = c;
                end
                cla_pkg::KIND_CUT: begin
                    // last stored character gives way to the terminator
                    len_next  = fill_reg - FW'(1);
                    fill_next = '0;
                    prev_next = c;
                end
                default: begin
                    fill_next = fill_reg;
                end
            endcase
        end
    end

    // read address runs one step ahead so rdata_reg tracks rd_idx_reg
    always_comb begin
        if (cmd.accept) begin
            rd_idx_next = '0;
        end else if (cmd.rd_adv) begin
            rd_idx_next = rd_idx_reg + AW'(1);
        end else begin
            rd_idx_next = rd_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            len_reg    <= '0;
            prev_reg   <= cla_pkg::CH_NUL;
            rd_idx_reg <= '0;
        end else begin
            fill_reg   <= fill_next;
            len_reg    <= len_next;
            prev_reg   <= prev_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            char_reg <= c;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && kind == cla_pkg::KIND_STORE) begin
            mem[fill_reg[AW-1:0]] <= c;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[rd_idx_next];
    end

    // output register
    logic                       sel_dest;
    logic [cla_pkg::CHAR_W-1:0] sel_data;

    always_comb begin
        case (cmd.sel)
            cla_pkg::SEL_CHAR: begin
                sel_dest = cla_pkg::DEST_ECHO;
                sel_data = char_reg;
            end
            cla_pkg::SEL_LF_ECHO: begin
                sel_dest = cla_pkg::DEST_ECHO;
                sel_data = cla_pkg::CH_LF;
            end
            cla_pkg::SEL_LF_LINE: begin
                sel_dest = cla_pkg::DEST_LINE;
                sel_data = cla_pkg::CH_LF;
            end
            cla_pkg::SEL_MEM: begin
                sel_dest = cla_pkg::DEST_LINE;
                sel_data = rdata_reg;
            end
            default: begin
                sel_dest = cla_pkg::DEST_LINE;
                sel_data = cla_pkg::CH_NUL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_dest_reg <= sel_dest;
            out_data_reg <= sel_data;
            out_last_reg <= cmd.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};
    assign m_tuser  = out_dest_reg;
    assign m_tlast  = out_last_reg;

    assign status.kind       = kind;
    assign status.out_free   = !out_valid_reg || m_tready;
    assign status.line_empty = (len_reg == '0);
    assign status.rd_last    = (FW'(rd_idx_reg) == len_reg - FW'(1));

endmodule
